@@ hdl/magnetometer_hard_iron_calibrator_defines.svh @@
// Assertion helpers shared by the calibrator's RTL.
`ifndef MAGNETOMETER_HARD_IRON_CALIBRATOR_DEFINES_SVH
`define MAGNETOMETER_HARD_IRON_CALIBRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HIC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hic_pkg.sv @@
package hic_pkg;

    localparam int POSITIONS = 13;
    localparam int CNT_W     = $clog2(POSITIONS + 1);

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_CANCEL = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_NOT  = 3'd0,
        ST_CAL  = 3'd1,
        ST_RUN  = 3'd2,
        ST_DONE = 3'd3,
        ST_FAIL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        SP_BEGIN = 3'd0,
        SP_HORIZ = 3'd1,
        SP_VERT  = 3'd2,
        SP_SAVE  = 3'd3,
        SP_DONE  = 3'd4
    } t_step;

    typedef enum logic [2:0] {
        CFG_PRESET_X  = 3'd0,
        CFG_PRESET_Y  = 3'd1,
        CFG_PRESET_Z  = 3'd2,
        CFG_PRESET_OK = 3'd3,
        CFG_YAW_TOL   = 3'd4,
        CFG_Z_TARGET  = 3'd5,
        CFG_STALL_LIM = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] preset_x;
        logic signed [15:0] preset_y;
        logic signed [15:0] preset_z;
        logic               preset_valid;
        logic [10:0]        yaw_tol;
        logic [15:0]        z_target;
        logic [15:0]        stall_limit;
    } t_cfg;

    // State as it stands after the item in flight has been applied.
    typedef struct packed {
        t_status            status;
        t_step              step;
        logic [CNT_W-1:0]   count;
        logic signed [15:0] ofs_x;
        logic signed [15:0] ofs_y;
        logic signed [15:0] ofs_z;
    } t_view;

endpackage

@@ hdl/hic_yaw_match.sv @@
module hic_yaw_match
    import hic_pkg::*;
(
    input  logic signed [11:0]    i_yaw,
    input  logic [10:0]           i_tol,
    output logic [POSITIONS-1:0]  o_hit
);

    // One comparator per heading; headings are evenly spaced from -180 to +180 degrees.
    for (genvar g = 0; g < POSITIONS; g++) begin : g_pos
        localparam int POS_I = -1800 + (3600 * g) / (POSITIONS - 1);
        logic signed [12:0] w_diff;
        logic        [12:0] w_mag;

        assign w_diff   = 13'(POS_I) - {i_yaw[11], i_yaw};
        assign w_mag    = w_diff[12] ? 13'(-w_diff) : 13'(w_diff);
        assign o_hit[g] = (w_mag < {2'b00, i_tol});
    end

endmodule

@@ hdl/hic_cal_fsm.sv @@
module hic_cal_fsm
    import hic_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  t_func                 i_func,
    input  logic signed [15:0]    i_raw_x,
    input  logic signed [15:0]    i_raw_y,
    input  logic signed [15:0]    i_raw_z,
    input  logic [POSITIONS-1:0]  i_hit,
    input  t_cfg                  i_cfg,
    output t_view                 o_view
);

    t_step              r_step,     n_step;
    t_status            r_status,   n_status;
    logic               r_load,     n_load;
    logic               r_ofs_ok,   n_ofs_ok;
    logic signed [15:0] r_ofs_x,    n_ofs_x;
    logic signed [15:0] r_ofs_y,    n_ofs_y;
    logic signed [15:0] r_ofs_z,    n_ofs_z;
    logic signed [15:0] r_min_x,    n_min_x;
    logic signed [15:0] r_min_y,    n_min_y;
    logic signed [15:0] r_min_z,    n_min_z;
    logic signed [15:0] r_max_x,    n_max_x;
    logic signed [15:0] r_max_y,    n_max_y;
    logic signed [15:0] r_max_z,    n_max_z;
    logic [POSITIONS-1:0] r_mask,   n_mask;
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [15:0]        r_vcount,   n_vcount;
    logic [15:0]        r_stall,    n_stall;

    // Midpoint of max and min, rounded toward zero.
    function automatic logic signed [15:0] f_half(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        s = s + 17'(s[16]);
        return s[16:1];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= SP_BEGIN;
            r_status <= ST_NOT;
            r_load   <= 1'b1;
            r_ofs_ok <= 1'b0;
            r_ofs_x  <= '0;
            r_ofs_y  <= '0;
            r_ofs_z  <= '0;
            r_min_x  <= '0;
            r_min_y  <= '0;
            r_min_z  <= '0;
            r_max_x  <= '0;
            r_max_y  <= '0;
            r_max_z  <= '0;
            r_mask   <= '0;
            r_count  <= '0;
            r_vcount <= '0;
            r_stall  <= '0;
        end else if (i_fire) begin
            r_step   <= n_step;
            r_status <= n_status;
            r_load   <= n_load;
            r_ofs_ok <= n_ofs_ok;
            r_ofs_x  <= n_ofs_x;
            r_ofs_y  <= n_ofs_y;
            r_ofs_z  <= n_ofs_z;
            r_min_x  <= n_min_x;
            r_min_y  <= n_min_y;
            r_min_z  <= n_min_z;
            r_max_x  <= n_max_x;
            r_max_y  <= n_max_y;
            r_max_z  <= n_max_z;
            r_mask   <= n_mask;
            r_count  <= n_count;
            r_vcount <= n_vcount;
            r_stall  <= n_stall;
        end
    end

    always_comb begin
        n_step   = r_step;
        n_status = r_status;
        n_load   = r_load;
        n_ofs_ok = r_ofs_ok;
        n_ofs_x  = r_ofs_x;
        n_ofs_y  = r_ofs_y;
        n_ofs_z  = r_ofs_z;
        n_min_x  = r_min_x;
        n_min_y  = r_min_y;
        n_min_z  = r_min_z;
        n_max_x  = r_max_x;
        n_max_y  = r_max_y;
        n_max_z  = r_max_z;
        n_mask   = r_mask;
        n_count  = r_count;
        n_vcount = r_vcount;
        n_stall  = r_stall;

        // The first item after reset picks up the stored offsets.
        if (r_load) begin
            n_load   = 1'b0;
            n_ofs_x  = i_cfg.preset_x;
            n_ofs_y  = i_cfg.preset_y;
            n_ofs_z  = i_cfg.preset_z;
            n_ofs_ok = i_cfg.preset_valid;
            n_status = i_cfg.preset_valid ? ST_CAL : ST_NOT;
        end

        priority if (i_func == FUNC_START) begin
            n_status = ST_RUN;
            n_step   = SP_BEGIN;
            n_min_x  = '0;
            n_min_y  = '0;
            n_min_z  = '0;
            n_max_x  = '0;
            n_max_y  = '0;
            n_max_z  = '0;
            n_mask   = '0;
            n_count  = '0;
            n_vcount = '0;
            n_stall  = '0;
        end else if (i_func == FUNC_CANCEL) begin
            n_step   = SP_BEGIN;
            n_stall  = '0;
            n_status = n_ofs_ok ? ST_CAL : ST_NOT;
        end else if (n_status == ST_RUN) begin
            unique case (r_step)
                SP_BEGIN: begin
                    n_mask   = '0;
                    n_count  = '0;
                    n_vcount = '0;
                    n_step   = SP_HORIZ;
                end
                SP_HORIZ: begin
                    n_mask  = r_mask | i_hit;
                    n_count = CNT_W'($countones(n_mask));
                    if (i_raw_x < r_min_x) n_min_x = i_raw_x;
                    if (i_raw_x > r_max_x) n_max_x = i_raw_x;
                    if (i_raw_y < r_min_y) n_min_y = i_raw_y;
                    if (i_raw_y > r_max_y) n_max_y = i_raw_y;
                    if (n_count >= CNT_W'(POSITIONS)) begin
                        n_mask   = '0;
                        n_count  = '0;
                        n_vcount = '0;
                        n_step   = SP_VERT;
                    end
                end
                SP_VERT: begin
                    n_vcount = r_vcount + 16'd1;
                    if (i_raw_z < r_min_z) n_min_z = i_raw_z;
                    if (i_raw_z > r_max_z) n_max_z = i_raw_z;
                    if (n_vcount >= i_cfg.z_target) begin
                        n_vcount = '0;
                        n_step   = SP_SAVE;
                    end
                end
                SP_SAVE: begin
                    n_ofs_x  = f_half(r_max_x, r_min_x);
                    n_ofs_y  = f_half(r_max_y, r_min_y);
                    n_ofs_z  = f_half(r_max_z, r_min_z);
                    n_ofs_ok = 1'b1;
                    n_step   = SP_DONE;
                end
                default: begin
                end
            endcase

            if (n_step == SP_DONE) n_status = ST_DONE;

            n_stall = (r_stall == 16'hFFFF) ? r_stall : r_stall + 16'd1;
            if (n_step != r_step) begin
                n_stall = '0;
            end else if (n_stall > i_cfg.stall_limit) begin
                n_stall  = '0;
                n_status = ST_FAIL;
            end
        end else if (n_status == ST_DONE || n_status == ST_FAIL) begin
            n_step   = SP_BEGIN;
            n_stall  = '0;
            n_status = n_ofs_ok ? ST_CAL : ST_NOT;
        end else begin
            // A tick while idle does no calibration work; only the correction applies.
        end
    end

    assign o_view.status = n_status;
    assign o_view.step   = n_step;
    assign o_view.count  = n_count;
    assign o_view.ofs_x  = n_ofs_x;
    assign o_view.ofs_y  = n_ofs_y;
    assign o_view.ofs_z  = n_ofs_z;

endmodule

@@ hdl/magnetometer_hard_iron_calibrator.sv @@
// Magnetometer hard-iron calibrator, min/max method.
// Input channel (i_in_valid / o_in_ready): one request per item, carrying a
// command code (sample tick, start, cancel) with one X/Y/Z sample and a yaw.
// Output channel (o_out_valid / i_out_ready): exactly one result per request,
// holding the sample with offsets removed when calibrated, plus the
// calibration status, step, collection flag and headings reached so far.
// Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata) and
// must only be written while no request is in flight.
// A request sits in the input register; when the result stage advances, all state
// updates and the correction land in the result register. Throughput is one
// request per cycle while the receiver keeps i_out_ready high; the thirteen heading
// comparators and the min/max trackers all run in that single stage.
// When the receiver stalls, the result register holds and the input register
// still takes one more request, then o_in_ready drops until the result moves.
// Reset is synchronous, active low: both registers empty, configuration back
// to its defaults, status not calibrated. The stored offsets are copied in
// with the first request after reset.
`include "magnetometer_hard_iron_calibrator_defines.svh"

module magnetometer_hard_iron_calibrator
    import hic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_raw_x,
    input  logic signed [15:0] i_raw_y,
    input  logic signed [15:0] i_raw_z,
    input  logic signed [11:0] i_yaw,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_corrected_x,
    output logic signed [15:0] o_corrected_y,
    output logic signed [15:0] o_corrected_z,
    output logic               o_was_corrected,
    output logic [2:0]         o_cal_status,
    output logic [2:0]         o_cal_step,
    output logic               o_collecting,
    output logic [3:0]         o_positions_reached
);

    t_cfg                 r_cfg;
    logic                 r_in_vld;
    t_func                r_in_func;
    logic signed [15:0]   r_in_x;
    logic signed [15:0]   r_in_y;
    logic signed [15:0]   r_in_z;
    logic signed [11:0]   r_in_yaw;
    logic                 r_out_vld;
    logic signed [15:0]   r_out_x;
    logic signed [15:0]   r_out_y;
    logic signed [15:0]   r_out_z;
    logic                 r_out_corr;
    t_status              r_out_status;
    t_step                r_out_step;
    logic                 r_out_coll;
    logic [CNT_W-1:0]     r_out_count;

    logic                 w_adv;
    logic                 w_fire;
    logic                 w_accept;
    logic                 w_corr;
    logic [POSITIONS-1:0] w_hit;
    t_view                w_view;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preset_x     <= '0;
            r_cfg.preset_y     <= '0;
            r_cfg.preset_z     <= '0;
            r_cfg.preset_valid <= 1'b0;
            r_cfg.yaw_tol      <= 11'd50;
            r_cfg.z_target     <= 16'd1000;
            r_cfg.stall_limit  <= 16'd1500;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PRESET_X:  r_cfg.preset_x     <= i_cfg_wdata;
                CFG_PRESET_Y:  r_cfg.preset_y     <= i_cfg_wdata;
                CFG_PRESET_Z:  r_cfg.preset_z     <= i_cfg_wdata;
                CFG_PRESET_OK: r_cfg.preset_valid <= i_cfg_wdata[0];
                CFG_YAW_TOL:   r_cfg.yaw_tol      <= i_cfg_wdata[10:0];
                CFG_Z_TARGET:  r_cfg.z_target     <= i_cfg_wdata;
                CFG_STALL_LIM: r_cfg.stall_limit  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The work stage advances whenever the result register is empty or being drained.
    assign w_adv      = !r_out_vld || i_out_ready;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_func <= t_func'(i_func);
            r_in_x    <= i_raw_x;
            r_in_y    <= i_raw_y;
            r_in_z    <= i_raw_z;
            r_in_yaw  <= i_yaw;
        end
    end

    hic_yaw_match u_yaw (
        .i_yaw (r_in_yaw),
        .i_tol (r_cfg.yaw_tol),
        .o_hit (w_hit)
    );

    hic_cal_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_func  (r_in_func),
        .i_raw_x (r_in_x),
        .i_raw_y (r_in_y),
        .i_raw_z (r_in_z),
        .i_hit   (w_hit),
        .i_cfg   (r_cfg),
        .o_view  (w_view)
    );

    // Correction uses the status and offsets as they stand after this request.
    assign w_corr = (w_view.status == ST_CAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_x      <= r_in_x - (w_corr ? w_view.ofs_x : 16'sd0);
            r_out_y      <= r_in_y - (w_corr ? w_view.ofs_y : 16'sd0);
            r_out_z      <= r_in_z - (w_corr ? w_view.ofs_z : 16'sd0);
            r_out_corr   <= w_corr;
            r_out_status <= w_view.status;
            r_out_step   <= w_view.step;
            r_out_coll   <= (w_view.status == ST_RUN) &&
                            (w_view.step == SP_HORIZ || w_view.step == SP_VERT);
            r_out_count  <= w_view.count;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_corrected_x       = r_out_x;
    assign o_corrected_y       = r_out_y;
    assign o_corrected_z       = r_out_z;
    assign o_was_corrected     = r_out_corr;
    assign o_cal_status        = r_out_status;
    assign o_cal_step          = r_out_step;
    assign o_collecting        = r_out_coll;
    assign o_positions_reached = 4'(r_out_count);

    // A request held in the input register is never dropped while the result stage is blocked.
    `HIC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_vld && !w_adv, r_in_vld && $stable(r_in_func), "held request lost")
    // Collection is only reported while a calibration is running.
    `HIC_ASSERT_SAME(a_coll_run, i_clk, i_rst_n, r_out_vld && r_out_coll, r_out_status == ST_RUN, "collecting outside a run")
    // Correction is applied exactly when the reported status is calibrated.
    `HIC_ASSERT_SAME(a_corr_cal, i_clk, i_rst_n, r_out_vld, r_out_corr == (r_out_status == ST_CAL), "correction flag mismatch")
    // A full set of headings moves on to the vertical step at once, so the count never shows it.
    `HIC_ASSERT_SAME(a_count_lim, i_clk, i_rst_n, r_out_vld, r_out_count < CNT_W'(POSITIONS), "heading count overflow")

endmodule

@@ test/magnetometer_hard_iron_calibrator_tb.sv @@
module magnetometer_hard_iron_calibrator_tb;
    import hic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Code 3 on the command field is not a command; the block takes it as a sample tick.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         NUM_PHASES  = 9;
    localparam int         PHASE_ITEMS = 200;

    // One request as it goes into the block.
    typedef struct {
        logic [1:0]         func;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [11:0] yaw;
    } t_cal_request;

    // One result as the block should return it.
    typedef struct {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic        corr;
        logic [2:0]  status;
        logic [2:0]  step;
        logic        coll;
        logic [3:0]  count;
    } t_cal_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_addr = '0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_func = '0;
    logic signed [15:0] i_raw_x = '0;
    logic signed [15:0] i_raw_y = '0;
    logic signed [15:0] i_raw_z = '0;
    logic signed [11:0] i_yaw = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_corrected_x;
    logic signed [15:0] o_corrected_y;
    logic signed [15:0] o_corrected_z;
    logic               o_was_corrected;
    logic [2:0]         o_cal_status;
    logic [2:0]         o_cal_step;
    logic               o_collecting;
    logic [3:0]         o_positions_reached;

    magnetometer_hard_iron_calibrator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_raw_x             (i_raw_x),
        .i_raw_y             (i_raw_y),
        .i_raw_z             (i_raw_z),
        .i_yaw               (i_yaw),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_corrected_x       (o_corrected_x),
        .o_corrected_y       (o_corrected_y),
        .o_corrected_z       (o_corrected_z),
        .o_was_corrected     (o_was_corrected),
        .o_cal_status        (o_cal_status),
        .o_cal_step          (o_cal_step),
        .o_collecting        (o_collecting),
        .o_positions_reached (o_positions_reached)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be driven, and results the block still owes us.
    t_cal_request pending_requests[$];
    t_cal_result  expected_results[$];

    int n_queued   = 0;
    int n_directed = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_saved    = 0;
    int n_stalled  = 0;
    int n_settings = 0;

    // Configuration as the calibrator should currently hold it.
    logic signed [15:0] m_preset [3] = '{16'sd0, 16'sd0, 16'sd0};
    logic               m_preset_ok = 1'b0;
    logic [10:0]        m_yaw_tol   = 11'd50;
    logic [15:0]        m_z_target  = 16'd1000;
    logic [15:0]        m_stall_lim = 16'd1500;

    // Calibration state, starting from its reset values.
    t_step                m_step         = SP_BEGIN;
    t_status              m_status       = ST_NOT;
    bit                   m_load_pending = 1'b1;
    bit                   m_offsets_ok   = 1'b0;
    int                   m_ofs [3]      = '{0, 0, 0};
    int                   m_min [3]      = '{0, 0, 0};
    int                   m_max [3]      = '{0, 0, 0};
    logic [POSITIONS-1:0] m_visited      = '0;
    int                   m_visited_cnt  = 0;
    logic [15:0]          m_vert_cnt     = '0;
    logic [15:0]          m_stall        = '0;

    function automatic void track_axis(input int a, input int v);
        if (v < m_min[a]) m_min[a] = v;
        if (v > m_max[a]) m_max[a] = v;
    endfunction

    // Advances the calibration state by one request and works out the result
    // that the block should give for it.
    task automatic hard_iron_predict(input t_cal_request rq, output t_cal_result res);
        int    s [3];
        int    yaw_v;
        int    pos;
        int    yaw_dist;
        t_step prev;
        bit    corr;
        s[0]  = rq.x;
        s[1]  = rq.y;
        s[2]  = rq.z;
        yaw_v = rq.yaw;

        // The stored offsets come in with the very first request after reset.
        if (m_load_pending) begin
            m_load_pending = 1'b0;
            for (int a = 0; a < 3; a++) m_ofs[a] = m_preset[a];
            m_offsets_ok = m_preset_ok;
            m_status     = m_offsets_ok ? ST_CAL : ST_NOT;
        end

        if (rq.func == FUNC_START) begin
            // A start also restarts a calibration that is already running.
            m_status = ST_RUN;
            m_step   = SP_BEGIN;
            for (int a = 0; a < 3; a++) begin
                m_min[a] = 0;
                m_max[a] = 0;
            end
            m_visited     = '0;
            m_visited_cnt = 0;
            m_vert_cnt    = '0;
            m_stall       = '0;
        end else if (rq.func == FUNC_CANCEL) begin
            m_step   = SP_BEGIN;
            m_stall  = '0;
            m_status = m_offsets_ok ? ST_CAL : ST_NOT;
        end else if (m_status == ST_RUN) begin
            prev = m_step;
            case (m_step)
                SP_BEGIN: begin
                    m_visited     = '0;
                    m_visited_cnt = 0;
                    m_vert_cnt    = '0;
                    m_step        = SP_HORIZ;
                end
                SP_HORIZ: begin
                    // Headings sit evenly from -180.0 to +180.0 degrees, in tenths.
                    for (int i = 0; i < POSITIONS; i++) begin
                        pos      = -1800 + (3600 * i) / (POSITIONS - 1);
                        yaw_dist = pos - yaw_v;
                        if (yaw_dist < 0) yaw_dist = -yaw_dist;
                        if (!m_visited[i] && yaw_dist < int'(m_yaw_tol)) begin
                            m_visited[i] = 1'b1;
                            m_visited_cnt++;
                        end
                    end
                    track_axis(0, s[0]);
                    track_axis(1, s[1]);
                    if (m_visited_cnt >= POSITIONS) begin
                        m_visited     = '0;
                        m_visited_cnt = 0;
                        m_vert_cnt    = '0;
                        m_step        = SP_VERT;
                    end
                end
                SP_VERT: begin
                    m_vert_cnt = m_vert_cnt + 16'd1;
                    track_axis(2, s[2]);
                    if (m_vert_cnt >= m_z_target) begin
                        m_vert_cnt = '0;
                        m_step     = SP_SAVE;
                    end
                end
                SP_SAVE: begin
                    // Offsets are the midpoint of each range, truncated toward zero.
                    for (int a = 0; a < 3; a++) m_ofs[a] = (m_max[a] + m_min[a]) / 2;
                    m_offsets_ok = 1'b1;
                    m_step       = SP_DONE;
                    n_saved++;
                end
                default: ;
            endcase
            if (m_step == SP_DONE) m_status = ST_DONE;

            // Ticks spent in one step count up; past the limit the run fails.
            if (m_stall != 16'hFFFF) m_stall = m_stall + 16'd1;
            if (m_step != prev) begin
                m_stall = '0;
            end else if (m_stall > m_stall_lim) begin
                m_stall  = '0;
                m_status = ST_FAIL;
                n_stalled++;
            end
        end else if (m_status == ST_DONE || m_status == ST_FAIL) begin
            m_step   = SP_BEGIN;
            m_stall  = '0;
            m_status = m_offsets_ok ? ST_CAL : ST_NOT;
        end

        corr       = (m_status == ST_CAL);
        res.cx     = 16'(s[0] - (corr ? m_ofs[0] : 0));
        res.cy     = 16'(s[1] - (corr ? m_ofs[1] : 0));
        res.cz     = 16'(s[2] - (corr ? m_ofs[2] : 0));
        res.corr   = corr;
        res.status = m_status;
        res.step   = m_step;
        res.coll   = (m_status == ST_RUN) && (m_step == SP_HORIZ || m_step == SP_VERT);
        res.count  = 4'(m_visited_cnt);
    endtask

    // Mostly short gaps, now and then a long one; a steady stretch has none.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_yaw();
        return int'($urandom_range(0, 3600)) - 1800;
    endfunction

    task automatic queue_request(input logic [1:0] f, input logic [15:0] x,
                                 input logic [15:0] y, input logic [15:0] z, input int yv);
        t_cal_request rq;
        rq.func = f;
        rq.x    = x;
        rq.y    = y;
        rq.z    = z;
        rq.yaw  = 12'(yv);
        pending_requests.push_back(rq);
        n_queued++;
    endtask

    // One request of a calibration run. A mangled run now and then has a
    // stray command slipped in ahead of the request, which can break the run.
    task automatic queue_run_item(input bit mangle, input logic [1:0] f, input int yv);
        logic [1:0] stray;
        if (mangle && $urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
                0:       stray = FUNC_CANCEL;
                1:       stray = FUNC_START;
                default: stray = FUNC_UNUSED;
            endcase
            queue_request(stray, rand_raw(), rand_raw(), rand_raw(), rand_yaw());
        end
        queue_request(f, rand_raw(), rand_raw(), rand_raw(), yv);
    endtask

    // A full calibration: start, the thirteen headings in random order with some
    // wandering in between, the vertical samples, then save, done and a few
    // corrected samples.
    task automatic queue_cal_run(input int z_ticks);
        int order [POSITIONS];
        int j;
        int tmp;
        int span;
        int off;
        int yv;
        bit mangle;
        mangle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < POSITIONS; i++) order[i] = i;
        for (int i = POSITIONS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // Stay inside the tolerance; with a zero tolerance nothing can be reached.
        span = (m_yaw_tol == 0) ? 40 : ((int'(m_yaw_tol) - 1 > 40) ? 40 : int'(m_yaw_tol) - 1);

        queue_run_item(mangle, FUNC_START, rand_yaw());
        queue_run_item(mangle, FUNC_TICK, rand_yaw());
        for (int i = 0; i < POSITIONS; i++) begin
            repeat ($urandom_range(0, 2)) queue_run_item(mangle, FUNC_TICK, rand_yaw());
            off = $urandom_range(0, span);
            if ($urandom_range(0, 1) == 1) off = -off;
            yv = -1800 + (3600 * order[i]) / (POSITIONS - 1) + off;
            if (yv > 1800) yv = 1800;
            if (yv < -1800) yv = -1800;
            queue_run_item(mangle, FUNC_TICK, yv);
        end
        repeat (z_ticks) queue_run_item(mangle, FUNC_TICK, rand_yaw());
        repeat ($urandom_range(3, 6)) queue_run_item(mangle, FUNC_TICK, rand_yaw());
    endtask

    // Register writes happen only while the block is idle, so the new value
    // takes effect in the model right away.
    task automatic set_register(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_PRESET_X:  m_preset[0] = val;
            CFG_PRESET_Y:  m_preset[1] = val;
            CFG_PRESET_Z:  m_preset[2] = val;
            CFG_PRESET_OK: m_preset_ok = val[0];
            CFG_YAW_TOL:   m_yaw_tol   = val[10:0];
            CFG_Z_TARGET:  m_z_target  = val;
            CFG_STALL_LIM: m_stall_lim = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Checks on the falling edge so that nothing races the clocked processes.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            n_errors++;
        end
    endtask

    // Request driver. The model advances at the edge where a request is taken,
    // so the expected results line up in acceptance order.
    t_cal_request drv_item;
    int           drv_gap    = 0;
    bit           drv_steady = 1'b0;

    always @(posedge i_clk) begin : request_driver
        t_cal_result res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap = 0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) begin
                hard_iron_predict(drv_item, res);
                expected_results.push_back(res);
            end
            if ($urandom_range(0, 63) == 0) drv_steady = !drv_steady;
            if (drv_gap > 0) begin
                drv_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                drv_item = pending_requests.pop_front();
                i_func     <= drv_item.func;
                i_raw_x    <= drv_item.x;
                i_raw_y    <= drv_item.y;
                i_raw_z    <= drv_item.z;
                i_yaw      <= drv_item.yaw;
                i_in_valid <= 1'b1;
                drv_gap = pick_gap(drv_steady);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    int mon_hold   = 0;
    bit mon_steady = 1'b0;

    always @(posedge i_clk) begin : result_monitor
        t_cal_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            mon_hold = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("corrected_x", want.cx, o_corrected_x);
                    check_field("corrected_y", want.cy, o_corrected_y);
                    check_field("corrected_z", want.cz, o_corrected_z);
                    check_field("was_corrected", 16'(want.corr), 16'(o_was_corrected));
                    check_field("cal_status", 16'(want.status), 16'(o_cal_status));
                    check_field("cal_step", 16'(want.step), 16'(o_cal_step));
                    check_field("collecting", 16'(want.coll), 16'(o_collecting));
                    check_field("positions_reached", 16'(want.count),
                                16'(o_positions_reached));
                    n_checked++;
                end
            end
            if ($urandom_range(0, 63) == 0) mon_steady = !mon_steady;
            if (mon_hold > 0) begin
                mon_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                mon_hold = pick_gap(mon_steady);
            end
        end
    end

    initial begin : stimulus
        int tol;
        int zt;
        int sl;
        int phase_start;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Valid presets, X and Y at the extremes, picked up by the first request. The
        // other registers keep their reset values for the directed part.
        set_register(CFG_PRESET_X, 16'h8000);
        set_register(CFG_PRESET_Y, 16'h7FFF);
        set_register(CFG_PRESET_Z, 16'h1234);
        set_register(CFG_PRESET_OK, 16'd1);
        n_settings++;

        // Directed part: field extremes and corrections that wrap, the unused
        // command code, a cancel with nothing running, a start, hits on both
        // ends of the heading range, a heading just at and just inside the
        // tolerance, a restart while running and a cancel mid-run.
        queue_request(FUNC_TICK, 16'h8000, 16'h7FFF, 16'h0000, -1800);
        queue_request(FUNC_TICK, 16'h7FFF, 16'h8000, 16'hFFFF, 1800);
        queue_request(FUNC_UNUSED, 16'h5555, 16'hAAAA, 16'h8001, 0);
        queue_request(FUNC_CANCEL, 16'h0001, 16'hFFFE, 16'h7FFE, 1);
        queue_request(FUNC_START, 16'h1234, 16'h4321, 16'hABCD, -1);
        queue_request(FUNC_TICK, 16'h0100, 16'hFF00, 16'h0010, 0);
        queue_request(FUNC_TICK, 16'h8000, 16'h7FFF, 16'h8000, -1800);
        queue_request(FUNC_TICK, 16'h7FFF, 16'h8000, 16'h7FFF, 1800);
        queue_request(FUNC_TICK, 16'h0042, 16'h0043, 16'h0044, -1450);
        queue_request(FUNC_TICK, 16'hFFC0, 16'h0040, 16'h0000, -1451);
        queue_request(FUNC_TICK, 16'h2000, 16'hE000, 16'h1000, 1024);
        queue_request(FUNC_START, 16'h0000, 16'h0000, 16'h0000, -1024);
        queue_request(FUNC_TICK, 16'h0003, 16'h0005, 16'h0007, 600);
        queue_request(FUNC_TICK, 16'h8000, 16'h7FFF, 16'h8000, 0);
        queue_request(FUNC_CANCEL, 16'h7FFF, 16'h8000, 16'h7FFF, -600);
        queue_request(FUNC_TICK, 16'hFFFF, 16'h0001, 16'h8000, 900);
        queue_request(FUNC_UNUSED, 16'h0000, 16'hFFFF, 16'h7FFF, -900);
        n_directed = n_queued;
        wait_drained();

        // Random part: phases with different settings, the extremes among them.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin tol = 1800; zt = 1; sl = 65534; end
                1: begin tol = 1; zt = 0; sl = 200; end
                2: begin tol = 60; zt = 8; sl = 1; end
                3: begin tol = 0; zt = 5; sl = 30; end
                4: begin tol = $urandom_range(20, 300); zt = 65535; sl = 40; end
                5: begin tol = $urandom_range(20, 300); zt = $urandom_range(1, 30); sl = 65535; end
                default: begin
                    tol = $urandom_range(5, 400);
                    zt  = $urandom_range(1, 40);
                    sl  = $urandom_range(25, 400);
                end
            endcase
            // Presets only matter on the first request, but are rewritten anyway.
            if (ph == 5) begin
                set_register(CFG_PRESET_X, rand_raw());
                set_register(CFG_PRESET_Y, rand_raw());
                set_register(CFG_PRESET_Z, rand_raw());
                set_register(CFG_PRESET_OK, 16'($urandom_range(0, 1)));
            end
            set_register(CFG_YAW_TOL, 16'(tol));
            set_register(CFG_Z_TARGET, 16'(zt));
            set_register(CFG_STALL_LIM, 16'(sl));
            n_settings++;

            phase_start = n_queued;
            while (n_queued - phase_start < PHASE_ITEMS) begin
                repeat ($urandom_range(0, 3))
                    queue_request(2'($urandom_range(0, 3)), rand_raw(), rand_raw(),
                                  rand_raw(), rand_yaw());
                // A zero target ends after one sample; a huge one is cut short.
                queue_cal_run(zt == 0 ? 1 : (zt > 60 ? 60 : zt));
            end
            wait_drained();
            repeat (3) @(posedge i_clk);
        end

        repeat (6) @(posedge i_clk);
        $display("Summary: %0d requests (%0d directed) over %0d register settings, %0d results checked.",
                 n_queued, n_directed, n_settings, n_checked);
        $display("Summary: %0d calibrations saved offsets, %0d runs stalled out.",
                 n_saved, n_stalled);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin : watchdog
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
